### rtl/linear_blend_skinning_macros.svh
// Assertion macros used by the skinning engine RTL (included by lbs_back).
// No dependencies; included inside module bodies.
`ifndef LINEAR_BLEND_SKINNING_MACROS_SVH
`define LINEAR_BLEND_SKINNING_MACROS_SVH

// same-cycle implication, disabled during reset
`define LBS_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define LBS_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error(msg);

`endif

### rtl/lbs_pkg.sv
// Types, codes and helpers for the skinning engine.
// No dependencies.
`default_nettype none
package lbs_pkg;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_SKINNED = 2'd1,
		OP_RIGID   = 2'd2,
		OP_NONE    = 2'd3
	} lbs_op_t;

	localparam int WORDS_PER_MATRIX = 12;
	localparam int LANES            = 4;
	localparam int QDEPTH           = 4;
	localparam logic [15:0] WEIGHT_ONE = 16'h8000;
	localparam logic [1:0]  REG_TINT   = 2'd0;

	typedef struct packed {
		logic        is_load;
		logic [7:0]  slot;
		logic [3:0]  elem;
		logic [31:0] value;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [31:0] bones;
		logic [63:0] weights;
		logic [3:0]  mask;
		logic [31:0] color;
	} lbs_entry_t;

	typedef struct packed {
		logic       valid;
		lbs_entry_t entry;
	} lbs_head_t;

	// round(c * t / 255) per channel
	function automatic logic [31:0] tint_mul(input logic [31:0] col, input logic [31:0] tint);
		logic [31:0] res;
		logic [16:0] y;
		logic [16:0] q;
		res = '0;
		for (int ch = 0; ch < 4; ch++) begin
			y = 17'(col[8*ch +: 8] * tint[8*ch +: 8]) + 17'd128;
			q = (y + (y >> 8)) >> 8;
			res[8*ch +: 8] = q[7:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### rtl/lbs_if.sv
// Item and result channel interfaces of the skinning engine.
// Valid/ready handshake; no dependencies.
`default_nettype none
interface lbs_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  matrix_slot;
	logic [3:0]  element_index;
	logic [31:0] element_value;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [31:0] bone_indices;
	logic [63:0] influence_weights;
	logic [31:0] vertex_color;
	modport source (output valid, opcode, matrix_slot, element_index, element_value,
		pos_x, pos_y, pos_z, bone_indices, influence_weights, vertex_color, input ready);
	modport sink (input valid, opcode, matrix_slot, element_index, element_value,
		pos_x, pos_y, pos_z, bone_indices, influence_weights, vertex_color, output ready);
endinterface

interface lbs_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [31:0] out_z;
	logic [31:0] out_color;
	logic        overflow;
	modport source (output valid, out_x, out_y, out_z, out_color, overflow, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_color, overflow, output ready);
endinterface
`default_nettype wire

### rtl/linear_blend_skinning.sv
// Top level of the vertex skinning engine: APB tint register, front queue, back pipeline.
// Depends on lbs_pkg, lbs_if, lbs_front and lbs_back.
// Throughput: one palette load per cycle while the result is not stalled; a vertex
// fetches one palette matrix per non-zero influence lane (at least one; rigid: one).
// Path: a vertex goes from the front queue through stages s1 to s4 to the result register;
// further influence lanes issue one after another and are summed in the accumulator.
// Reset clears control state and sets the tint to all ones; palette is undefined until loaded.
`default_nettype none
module linear_blend_skinning #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int INFLUENCES      = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	lbs_item_if.sink         item,
	lbs_result_if.source     result
);
	import lbs_pkg::*;

	logic [31:0] tint_q;
	lbs_head_t   head;
	logic        pop;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_TINT) ? tint_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tint_q <= 32'hFFFFFFFF;
		else if (psel && penable && pwrite && (paddr == REG_TINT))
			tint_q <= pwdata;
	end

	lbs_front #(.INFLUENCES(INFLUENCES)) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.tint  (tint_q),
		.head  (head),
		.pop   (pop)
	);

	lbs_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.result(result)
	);
endmodule
`default_nettype wire

### rtl/lbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/lbs_front.sv
// Front end: accepts items, classifies them, tints colour, queues them in order (OP_NONE items are dropped).
// Depends on lbs_pkg and lbs_if.
`default_nettype none
module lbs_front #(
	parameter int INFLUENCES = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	lbs_item_if.sink               item,
	input  wire logic [31:0]       tint,
	output lbs_pkg::lbs_head_t     head,
	input  wire logic              pop
);
	import lbs_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	lbs_entry_t      q_q [QDEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;
	logic            push;
	lbs_entry_t      ent;

	assign item.ready = (cnt_q != (PW+1)'(QDEPTH));
	assign push = item.valid && item.ready && (lbs_op_t'(item.opcode) != OP_NONE);

	always_comb begin
		ent         = '0;
		ent.is_load = (lbs_op_t'(item.opcode) == OP_LOAD);
		ent.slot    = item.matrix_slot;
		ent.elem    = item.element_index;
		ent.value   = item.element_value;
		ent.px      = item.pos_x;
		ent.py      = item.pos_y;
		ent.pz      = item.pos_z;
		ent.bones   = item.bone_indices;
		ent.color   = tint_mul(item.vertex_color, tint);
		if (lbs_op_t'(item.opcode) == OP_RIGID) begin
			ent.weights[15:0] = WEIGHT_ONE;
			ent.mask          = 4'b0001;
		end else begin
			ent.weights = item.influence_weights;
			for (int i = 0; i < LANES; i++)
				ent.mask[i] = (i < INFLUENCES) && (item.influence_weights[16*i +: 16] != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_q[wr_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.entry = q_q[rd_q];
endmodule
`default_nettype wire

### rtl/lbs_back.sv
// Back end: palette memories, lane sequencer, transform and blend pipeline.
// Depends on lbs_pkg, lbs_if, lbs_ram and the assertion macros.
`default_nettype none
module lbs_back #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lbs_pkg::lbs_head_t head,
	output logic                   pop,
	lbs_result_if.source           result
);
	import lbs_pkg::*;
	`include "linear_blend_skinning_macros.svh"

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	lbs_entry_t e;
	logic       adv, issue, load_do, last, busy_q;
	logic [3:0] rem_q, cur, onehot, rem_next;
	logic [1:0] lane;
	logic [7:0] bone;
	logic [31:0] rd [WORDS_PER_MATRIX];

	logic               v_s1, first_s1, last_s1, oor_s1;
	logic [15:0]        w_s1, w_s2, w_s3;
	logic [31:0]        px_s1, py_s1, pz_s1, col_s1, col_s2, col_s3, col_s4;
	logic               v_s2, first_s2, last_s2, v_s3, first_s3, last_s3;
	logic               v_s4, first_s4, last_s4;
	logic signed [63:0] prod_s2 [9];
	logic signed [31:0] off_s2 [3];
	logic signed [49:0] t_s3 [3];
	logic signed [66:0] wt_s4 [3];
	logic signed [68:0] acc_q [3];
	logic signed [68:0] sum [3];
	logic               out_valid_q, ovf_q;
	logic [31:0]        ox_q, oy_q, oz_q, ocol_q;
	logic [31:0]        sat [3];
	logic [2:0]         ovf;
	logic [31:0]        pv [3];

	assign e   = head.entry;
	assign adv = !out_valid_q || result.ready;

	always_comb begin
		cur      = busy_q ? rem_q : e.mask;
		onehot   = cur & (~cur + 4'd1);
		rem_next = cur & ~onehot;
		last     = (rem_next == '0);
		case (onehot)
			4'b0010: lane = 2'd1;
			4'b0100: lane = 2'd2;
			4'b1000: lane = 2'd3;
			default: lane = 2'd0;
		endcase
		bone = e.bones[8*lane +: 8];
	end

	assign issue   = adv && head.valid && !e.is_load;
	assign load_do = adv && head.valid && e.is_load;
	assign pop     = load_do || (issue && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
		end else if (issue) begin
			busy_q <= !last;
			rem_q  <= rem_next;
		end
	end

	for (genvar g = 0; g < WORDS_PER_MATRIX; g++) begin : g_word
		lbs_ram #(.WIDTH(32), .DEPTH(PALETTE_ENTRIES)) u_ram (
			.clk  (clk),
			.we   (load_do && (e.elem == 4'(g)) && (32'(e.slot) < 32'(PALETTE_ENTRIES))),
			.waddr(AW'(e.slot)),
			.wdata(e.value),
			.re   (issue),
			.raddr(AW'(bone)),
			.rdata(rd[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	assign pv[0] = px_s1;
	assign pv[1] = py_s1;
	assign pv[2] = pz_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1 <= !busy_q;
			last_s1  <= last;
			oor_s1   <= (32'(bone) >= 32'(PALETTE_ENTRIES));
			w_s1     <= e.weights[16*lane +: 16];
			px_s1    <= e.px;
			py_s1    <= e.py;
			pz_s1    <= e.pz;
			col_s1   <= e.color;

			first_s2 <= first_s1; last_s2 <= last_s1; w_s2 <= w_s1; col_s2 <= col_s1;
			for (int r = 0; r < 3; r++) begin
				off_s2[r] <= oor_s1 ? '0 : $signed(rd[4*r+3]);
				for (int c = 0; c < 3; c++)
					prod_s2[3*r+c] <= oor_s1 ? 64'sd0 : $signed(rd[4*r+c]) * $signed(pv[c]);
			end

			first_s3 <= first_s2; last_s3 <= last_s2; w_s3 <= w_s2; col_s3 <= col_s2;
			for (int r = 0; r < 3; r++)
				t_s3[r] <= 50'(off_s2[r]) + 50'($signed(prod_s2[3*r][63:16]))
					+ 50'($signed(prod_s2[3*r+1][63:16]))
					+ 50'($signed(prod_s2[3*r+2][63:16]));

			first_s4 <= first_s3; last_s4 <= last_s3; col_s4 <= col_s3;
			for (int r = 0; r < 3; r++)
				wt_s4[r] <= t_s3[r] * $signed({1'b0, w_s3});
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = (first_s4 ? 69'sd0 : acc_q[r]) + 69'(wt_s4[r]);
			if ($signed(sum[r][68:15]) > 54'sd2147483647) begin
				sat[r] = 32'h7FFFFFFF; ovf[r] = 1'b1;
			end else if ($signed(sum[r][68:15]) < -54'sd2147483648) begin
				sat[r] = 32'h80000000; ovf[r] = 1'b1;
			end else begin
				sat[r] = sum[r][46:15]; ovf[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s4) begin
			for (int r = 0; r < 3; r++)
				acc_q[r] <= sum[r];
		end
		if (adv && v_s4 && last_s4) begin
			ox_q   <= sat[0];
			oy_q   <= sat[1];
			oz_q   <= sat[2];
			ocol_q <= col_s4;
			ovf_q  <= |ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= v_s4 && last_s4;
	end

	assign result.valid     = out_valid_q;
	assign result.out_x     = ox_q;
	assign result.out_y     = oy_q;
	assign result.out_z     = oz_q;
	assign result.out_color = ocol_q;
	assign result.overflow  = ovf_q;

	`LBS_ASSERT_NOW(a_busy_has_head, clk, arst_n, busy_q, head.valid && !e.is_load,
		"lane sequencer busy without a vertex at the queue head")
	`LBS_ASSERT_NEXT(a_last_gives_result, clk, arst_n, adv && v_s4 && last_s4, out_valid_q,
		"final lane did not produce a result")
	`LBS_ASSERT_NEXT(a_stall_freezes, clk, arst_n, out_valid_q && !result.ready,
		$stable(v_s1) && $stable(v_s4), "pipeline moved while the result was stalled")
	`LBS_ASSERT_NOW(a_no_pop_on_stall, clk, arst_n, !adv, !pop,
		"queue popped while the pipeline was stalled")
endmodule
`default_nettype wire
